/* hw/rtl/mrt_pkg.sv */
// Package for the multilevel radix trie map: codes, back-end states
// and fixed sizes shared by all modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrt_pkg;
  localparam int LEVEL_REGS = 4;
  localparam int LVL_W = $clog2(LEVEL_REGS);
  localparam int CNT_W = 3;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 4;

  localparam int DEF_MAX_LEVELS = 4;
  localparam int DEF_MAX_LEVEL_BITS = 8;
  localparam int DEF_INNER_NODES = 64;
  localparam int DEF_LEAF_ENTRIES = 1024;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL0_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL3_BITS = 3'd4;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_READ, B_CHECK, B_ALLOC, B_LEAF_WR, B_LEAF_RD, B_LEAF_OUT
  } back_state_t;
endpackage
`default_nettype wire

/* hw/rtl/multilevel_radix_trie_map.sv */
// Top level of the multilevel radix trie map: front end, request queue, back end.
// Depends on mrt_pkg, mrt_front, mrt_queue and mrt_back.
//
// Usage:
//   Raise start with opcode, key and entry_value; the request is taken at a
//   clock edge where start is high and busy is low. Opcode insert stores the
//   value under the key, opcode lookup returns it.
//   Each request yields one result: done is high for exactly one cycle with
//   status (ok or hit, lookup miss, pool exhausted) and found_value, which is
//   non-zero only on a lookup hit. The receiver cannot stall; take it then.
//   Configuration: cfg_write with cfg_index and cfg_data; index 0 sets the
//   level count, 1 to 4 the key bits per level. Write only while busy is low.
// Timing:
//   One request at a time. A request passes through the queue, then for each
//   level walked a registered read of the slot memory and a check of the slot,
//   then an allocation step per slot allocated on insert, then the leaf access:
//   a leaf write for an insert, a registered leaf read for a lookup hit, none
//   for a miss or a full pool. Busy falls in the cycle that done is high, so
//   the next request can be taken there.
// Reset:
//   rst (synchronous) clears the pools and starts a clearing pass over the
//   slot memory, one slot per cycle, over all INNER_NODES * 2**MAX_LEVEL_BITS
//   slots (16384 by default); busy stays high throughout.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_radix_trie_map #(
  parameter int MAX_LEVELS = mrt_pkg::DEF_MAX_LEVELS,
  parameter int MAX_LEVEL_BITS = mrt_pkg::DEF_MAX_LEVEL_BITS,
  parameter int INNER_NODES = mrt_pkg::DEF_INNER_NODES,
  parameter int LEAF_ENTRIES = mrt_pkg::DEF_LEAF_ENTRIES
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic opcode,
  input  wire logic [mrt_pkg::KEY_W-1:0] key,
  input  wire logic [mrt_pkg::VAL_W-1:0] entry_value,
  output logic done,
  output logic [1:0] status,
  output logic [mrt_pkg::VAL_W-1:0] found_value,
  input  wire logic cfg_write,
  input  wire logic [mrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mrt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrt_pkg::*;
  localparam int SL_W = LEVEL_REGS * MAX_LEVEL_BITS;
  localparam int QW = 1 + CNT_W + SL_W + VAL_W;

  logic accept;
  logic [CNT_W-1:0] levels;
  logic [LEVEL_REGS-1:0][MAX_LEVEL_BITS-1:0] slices;
  logic [QW-1:0] q_head;
  logic [1:0] q_count;
  logic q_pop;
  logic back_idle;

  // take a request only when nothing is in flight
  assign busy = (q_count != 2'd0) || !back_idle;
  assign accept = start && !busy;

  mrt_front #(
    .MAX_LEVELS(MAX_LEVELS),
    .MAX_LEVEL_BITS(MAX_LEVEL_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .key(key),
    .levels(levels),
    .slices(slices)
  );

  // hold classified requests until the back end is free
  mrt_queue #(
    .DW(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .push_data({opcode, levels, slices, entry_value}),
    .pop(q_pop),
    .head(q_head),
    .count(q_count)
  );

  mrt_back #(
    .MAX_LEVEL_BITS(MAX_LEVEL_BITS),
    .INNER_NODES(INNER_NODES),
    .LEAF_ENTRIES(LEAF_ENTRIES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .req_avail(q_count != 2'd0),
    .req_op(q_head[QW-1]),
    .req_levels(q_head[QW-2 -: CNT_W]),
    .req_slices(q_head[VAL_W +: SL_W]),
    .req_value(q_head[VAL_W-1:0]),
    .req_pop(q_pop),
    .idle(back_idle),
    .done(done),
    .status(status),
    .found_value(found_value)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
    else $error("illegal status code");

  a_value_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (found_value == '0))
    else $error("value returned without a hit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy dropped after a request was taken");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result with no request in flight");
endmodule
`default_nettype wire

/* hw/rtl/mrt_front.sv */
// Front end: configuration registers and key slicing of each accepted request.
// Depends on mrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrt_front #(
  parameter int MAX_LEVELS = mrt_pkg::DEF_MAX_LEVELS,
  parameter int MAX_LEVEL_BITS = mrt_pkg::DEF_MAX_LEVEL_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic [mrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mrt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [mrt_pkg::KEY_W-1:0] key,
  output logic [mrt_pkg::CNT_W-1:0] levels,
  output logic [mrt_pkg::LEVEL_REGS-1:0][MAX_LEVEL_BITS-1:0] slices
);
  import mrt_pkg::*;
  localparam int TOP = (MAX_LEVELS < LEVEL_REGS) ? MAX_LEVELS : LEVEL_REGS;

  logic [CNT_W-1:0] level_count;
  logic [LEVEL_REGS-1:0][CFG_DATA_W-1:0] level_bits;
  logic [LEVEL_REGS-1:0][CFG_DATA_W-1:0] width;
  logic [5:0] total;
  logic [5:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= CNT_W'(2);
      for (int i = 0; i < LEVEL_REGS; i++) level_bits[i] <= CFG_DATA_W'(8);
    end else if (cfg_write) begin
      if (cfg_index == REG_LEVEL_COUNT) level_count <= cfg_data[CNT_W-1:0];
      else if (cfg_index >= REG_LEVEL0_BITS && cfg_index <= REG_LEVEL3_BITS)
        level_bits[LVL_W'(cfg_index - REG_LEVEL0_BITS)] <= cfg_data;
    end
  end

  // clamp levels and widths into range
  always_comb begin
    levels = level_count;
    if (levels < CNT_W'(1)) levels = CNT_W'(1);
    if (levels > CNT_W'(TOP)) levels = CNT_W'(TOP);
    for (int i = 0; i < LEVEL_REGS; i++) begin
      width[i] = level_bits[i];
      if (width[i] < CFG_DATA_W'(1)) width[i] = CFG_DATA_W'(1);
      if (width[i] > CFG_DATA_W'(MAX_LEVEL_BITS)) width[i] = CFG_DATA_W'(MAX_LEVEL_BITS);
    end
  end

  // most significant slice feeds the top level
  always_comb begin
    total = '0;
    for (int i = 0; i < LEVEL_REGS; i++)
      if (CNT_W'(i) < levels) total = total + 6'(width[i]);
    acc = '0;
    for (int i = 0; i < LEVEL_REGS; i++) begin
      acc = acc + 6'(width[i]);
      slices[i] = MAX_LEVEL_BITS'(key >> (total - acc))
                & MAX_LEVEL_BITS'(((MAX_LEVEL_BITS+1)'(1) << width[i]) - (MAX_LEVEL_BITS+1)'(1));
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/mrt_queue.sv */
// Two-entry request queue between front and back ends.
// Depends on mrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrt_queue #(
  parameter int DW = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic pop,
  output logic [DW-1:0] head,
  output logic [1:0] count
);
  import mrt_pkg::*;
  logic [1:0][DW-1:0] slot;
  logic rd_ptr;
  logic wr_ptr;

  assign head = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && count != 2'd2) begin
        slot[wr_ptr] <= push_data;
        wr_ptr <= ~wr_ptr;
      end
      if (pop && count != 2'd0) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && count != 2'd2) ? 1 : 0)
                     - 2'((pop && count != 2'd0) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/mrt_back.sv */
// Back end: trie walk over the child-slot memory, pool allocation and leaf store.
// Depends on mrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrt_back #(
  parameter int MAX_LEVEL_BITS = mrt_pkg::DEF_MAX_LEVEL_BITS,
  parameter int INNER_NODES = mrt_pkg::DEF_INNER_NODES,
  parameter int LEAF_ENTRIES = mrt_pkg::DEF_LEAF_ENTRIES
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_avail,
  input  wire logic req_op,
  input  wire logic [mrt_pkg::CNT_W-1:0] req_levels,
  input  wire logic [mrt_pkg::LEVEL_REGS-1:0][MAX_LEVEL_BITS-1:0] req_slices,
  input  wire logic [mrt_pkg::VAL_W-1:0] req_value,
  output logic req_pop,
  output logic idle,
  output logic done,
  output logic [1:0] status,
  output logic [mrt_pkg::VAL_W-1:0] found_value
);
  import mrt_pkg::*;
  localparam int NW = (INNER_NODES > 1) ? $clog2(INNER_NODES) : 1;
  localparam int LW = (LEAF_ENTRIES > 1) ? $clog2(LEAF_ENTRIES) : 1;
  localparam int CW = (NW > LW) ? NW : LW;
  localparam int SAW = NW + MAX_LEVEL_BITS;
  localparam int SLOTS = INNER_NODES * (2 ** MAX_LEVEL_BITS);

  back_state_t state, state_next;

  logic [CW:0] slot_mem [SLOTS];
  logic [VAL_W-1:0] leaf_mem [LEAF_ENTRIES];
  logic [CW:0] slot_rdata;
  logic [VAL_W-1:0] leaf_rdata;

  logic op;
  logic [CNT_W-1:0] n;
  logic [LEVEL_REGS-1:0][MAX_LEVEL_BITS-1:0] slices;
  logic [VAL_W-1:0] value;
  logic [LVL_W-1:0] lvl;
  logic [NW-1:0] node;
  logic [LW-1:0] leaf;
  logic [NW:0] inner_used;
  logic [LW:0] leaves_used;
  logic [SAW-1:0] clr_addr;

  logic [SAW-1:0] walk_addr;
  logic last;
  logic [CW-1:0] child;
  logic hit;
  logic [CNT_W-1:0] need_inner;
  logic pools_fit;
  logic slot_we;
  logic [SAW-1:0] slot_waddr;
  logic [CW:0] slot_wdata;
  logic res_fire;
  logic [1:0] res_status;
  logic [VAL_W-1:0] res_value;

  assign walk_addr = {node, slices[lvl]};
  assign last = (CNT_W'(lvl) + CNT_W'(1)) == n;
  assign child = slot_rdata[CW-1:0];
  assign hit = slot_rdata[CW] &&
               (last ? ({1'b0, child} < (CW+1)'(LEAF_ENTRIES))
                     : ({1'b0, child} < (CW+1)'(INNER_NODES)));
  assign need_inner = n - CNT_W'(1) - CNT_W'(lvl);
  assign pools_fit = (({1'b0, inner_used} + (NW+2)'(need_inner)) <= (NW+2)'(INNER_NODES))
                  && (leaves_used < (LW+1)'(LEAF_ENTRIES));
  assign idle = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= B_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    req_pop = 1'b0;
    slot_we = 1'b0;
    slot_waddr = walk_addr;
    slot_wdata = '0;
    res_fire = 1'b0;
    res_status = ST_OK;
    res_value = '0;
    unique case (state)
      B_CLEAR: begin
        slot_we = 1'b1;
        slot_waddr = clr_addr;
        if (clr_addr == SAW'(SLOTS - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (req_avail) begin
          req_pop = 1'b1;
          state_next = B_READ;
        end
      end
      B_READ: state_next = B_CHECK;
      B_CHECK: begin
        if (hit) begin
          if (!last) state_next = B_READ;
          else if (op == OP_LOOKUP) state_next = B_LEAF_RD;
          else state_next = B_LEAF_WR;
        end else if (op == OP_LOOKUP) begin
          res_fire = 1'b1;
          res_status = ST_MISS;
          state_next = B_IDLE;
        end else if (!pools_fit) begin
          res_fire = 1'b1;
          res_status = ST_FULL;
          state_next = B_IDLE;
        end else begin
          state_next = B_ALLOC;
        end
      end
      B_ALLOC: begin
        slot_we = 1'b1;
        slot_wdata = last ? {1'b1, CW'(leaves_used[LW-1:0])}
                          : {1'b1, CW'(inner_used[NW-1:0])};
        if (last) state_next = B_LEAF_WR;
      end
      B_LEAF_WR: begin
        res_fire = 1'b1;
        state_next = B_IDLE;
      end
      B_LEAF_RD: state_next = B_LEAF_OUT;
      B_LEAF_OUT: begin
        res_fire = 1'b1;
        res_value = leaf_rdata;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rdata <= slot_mem[walk_addr];
    if (state == B_LEAF_WR) leaf_mem[leaf] <= value;
    leaf_rdata <= leaf_mem[leaf];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      inner_used <= (NW+1)'(1);
      leaves_used <= '0;
      done <= 1'b0;
    end else begin
      done <= res_fire;
      if (state == B_CLEAR) clr_addr <= clr_addr + SAW'(1);
      if (state == B_ALLOC) begin
        if (last) leaves_used <= leaves_used + (LW+1)'(1);
        else inner_used <= inner_used + (NW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    status <= res_status;
    found_value <= res_value;
    if (req_pop) begin
      op <= req_op;
      n <= req_levels;
      slices <= req_slices;
      value <= req_value;
      lvl <= '0;
      node <= '0;
    end
    if (state == B_CHECK && hit) begin
      if (last) leaf <= child[LW-1:0];
      else begin
        node <= child[NW-1:0];
        lvl <= lvl + LVL_W'(1);
      end
    end
    if (state == B_ALLOC) begin
      if (last) leaf <= leaves_used[LW-1:0];
      else begin
        node <= inner_used[NW-1:0];
        lvl <= lvl + LVL_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for multilevel_radix_trie_map: directed and random
// insert/lookup requests under several level settings, checked by a scoreboard.
// Depends on mrt_pkg and the multilevel_radix_trie_map RTL.
`timescale 1ns / 1ps
module tb_top;
  import mrt_pkg::*;

  localparam int SLOT_BITS = DEF_MAX_LEVEL_BITS;
  localparam int SLOT_TOTAL = DEF_INNER_NODES << DEF_MAX_LEVEL_BITS;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [1:0] st;
    logic [VAL_W-1:0] fv;
  } outcome_t;

  // Trie shadow: own copy of the slot store, the leaf words, both bump pools
  // and the level settings, plus the queue of outcomes still to arrive.
  class trie_scoreboard;
    bit [2:0] lvl_count;
    bit [3:0] lvl_bits[LEVEL_REGS];
    bit slot_valid[SLOT_TOTAL];
    int slot_child[SLOT_TOTAL];
    logic [VAL_W-1:0] leaf_vals[DEF_LEAF_ENTRIES];
    int inner_used;
    int leaves_used;
    outcome_t outstanding[$];
    int mismatches;

    function new();
      lvl_count = 2;
      foreach (lvl_bits[i]) lvl_bits[i] = 8;
      foreach (slot_valid[i]) slot_valid[i] = 0;
      foreach (slot_child[i]) slot_child[i] = 0;
      inner_used = 1;
      leaves_used = 0;
      mismatches = 0;
    endfunction

    function void set_reg(int idx, bit [3:0] data);
      if (idx == REG_LEVEL_COUNT) lvl_count = data[2:0];
      else if (idx <= REG_LEVEL3_BITS) lvl_bits[idx - REG_LEVEL0_BITS] = data;
    endfunction

    // Clamp out-of-range settings the way the block does.
    function int levels();
      int n;
      n = lvl_count;
      if (n < 1) n = 1;
      if (n > DEF_MAX_LEVELS) n = DEF_MAX_LEVELS;
      return n;
    endfunction

    function int width(int i);
      int b;
      b = lvl_bits[i];
      if (b < 1) b = 1;
      if (b > DEF_MAX_LEVEL_BITS) b = DEF_MAX_LEVEL_BITS;
      return b;
    endfunction

    // Walk the levels; return the level that missed, or n on a full path.
    function int walk(input bit [KEY_W-1:0] k, output int n, output int sl[LEVEL_REGS],
                      output int node, output int leaf);
      int total, acc, addr, c, miss, b;
      n = levels();
      total = 0;
      acc = 0;
      for (int i = 0; i < n; i++) total += width(i);
      for (int i = 0; i < n; i++) begin
        b = width(i);
        acc += b;
        sl[i] = (k >> (total - acc)) & ((1 << b) - 1);
      end
      node = 0;
      leaf = 0;
      miss = n;
      for (int i = 0; i < n; i++) begin
        addr = (node << SLOT_BITS) | sl[i];
        c = slot_child[addr];
        if (!slot_valid[addr] ||
            c >= ((i == n - 1) ? DEF_LEAF_ENTRIES : DEF_INNER_NODES)) begin
          miss = i;
          break;
        end
        if (i == n - 1) leaf = c;
        else node = c;
      end
      return miss;
    endfunction

    // True where a lookup would land on a leaf word never written.
    function bit hits_blank_leaf(bit [KEY_W-1:0] k);
      int n, node, leaf, miss;
      int sl[LEVEL_REGS];
      miss = walk(k, n, sl, node, leaf);
      return miss == n && leaf >= leaves_used;
    endfunction

    function void note(logic op, bit [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int n, node, leaf, miss, addr;
      int sl[LEVEL_REGS];
      outcome_t o;
      miss = walk(k, n, sl, node, leaf);
      o.st = ST_OK;
      o.fv = '0;
      if (op == OP_LOOKUP) begin
        if (miss < n) o.st = ST_MISS;
        else o.fv = leaf_vals[leaf];
      end else if (miss < n && (inner_used + (n - 1 - miss) > DEF_INNER_NODES ||
                                leaves_used + 1 > DEF_LEAF_ENTRIES)) begin
        o.st = ST_FULL;
      end else begin
        for (int i = miss; i < n; i++) begin
          addr = (node << SLOT_BITS) | sl[i];
          slot_valid[addr] = 1;
          if (i == n - 1) begin
            leaf = leaves_used++;
            slot_child[addr] = leaf;
          end else begin
            node = inner_used++;
            slot_child[addr] = node;
          end
        end
        leaf_vals[leaf] = v;
      end
      outstanding.push_back(o);
    endfunction

    function void check(logic [1:0] st, logic [VAL_W-1:0] fv);
      outcome_t o;
      if (outstanding.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d value %h", st, fv);
        return;
      end
      o = outstanding.pop_front();
      if (st !== o.st || fv !== o.fv) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                   o.st, st, o.fv, fv);
      end
    endfunction

    function int pending();
      return outstanding.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic opcode = OP_INSERT;
  logic [KEY_W-1:0] key = '0;
  logic [VAL_W-1:0] entry_value = '0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy, done;
  logic [1:0] status;
  logic [VAL_W-1:0] found_value;

  trie_scoreboard sb = new();
  bit [KEY_W-1:0] known_keys[$];
  int cycles = 0;

  multilevel_radix_trie_map dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .key(key),
    .entry_value(entry_value), .done(done), .status(status), .found_value(found_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Results cannot be held off: take every strobe as it comes.
  always @(posedge clk) begin
    if (!rst && done) sb.check(status, found_value);
  end

  // Guard against a hung block; the limit covers the clearing pass after
  // reset and every request at its slowest with the longest gaps.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hold the request until the block takes it, then record it.
  task send(logic op, bit [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int g;
    start <= 1'b1;
    opcode <= op;
    key <= k;
    entry_value <= v;
    do @(posedge clk); while (busy);
    sb.note(op, k, v);
    if (op == OP_INSERT) known_keys.push_back(k);
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result is in and the block idles.
  task drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write all five registers on consecutive edges; call only while idle.
  task write_levels(bit [3:0] cnt, bit [3:0] b0, bit [3:0] b1, bit [3:0] b2,
                    bit [3:0] b3);
    bit [3:0] vals[5];
    vals = '{cnt, b0, b1, b2, b3};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_LEVEL_COUNT + CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(REG_LEVEL_COUNT + i, vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Random requests: reuse stored keys most of the time so lookups hit and
  // inserts overwrite; turn a lookup that would land on a blank leaf into
  // an insert, which fills it.
  task random_phase(int count);
    logic op;
    bit [KEY_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT;
      if (known_keys.size() != 0 && $urandom_range(0, 9) < 6)
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else
        k = $urandom;
      if (op == OP_LOOKUP && sb.hits_blank_leaf(k)) op = OP_INSERT;
      send(op, k, pick_value());
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // hold off until the clearing pass is over
    while (busy) @(posedge clk);

    // Directed: default two levels of eight bits.
    send(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    send(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send(OP_LOOKUP, 32'h0000_00FF, 32'h0);
    send(OP_INSERT, 32'hABCD_0000, 32'hA5A5_5A5A);
    send(OP_LOOKUP, 32'h0000_0000, 32'h0);
    send(OP_INSERT, 32'h0000_0000, 32'h5A5A_A5A5);
    send(OP_LOOKUP, 32'h1234_0000, 32'h0);
    send(OP_INSERT, 32'h0000_8001, 32'hDEAD_BEEF);
    send(OP_LOOKUP, 32'hFFFF_8001, 32'h0);
    send(OP_LOOKUP, 32'h0000_8000, 32'h0);
    drain();

    // Four full levels: eats the inner node pool quickly.
    write_levels(4, 8, 8, 8, 8);
    random_phase(24);

    // Fill the leaf pool through a narrow top level.
    write_levels(2, 2, 8, 8, 8);
    for (int j = 0; j < DEF_LEAF_ENTRIES && sb.leaves_used < DEF_LEAF_ENTRIES; j++)
      send(OP_INSERT, ($urandom & ~32'h3FF) | j, pick_value());
    drain();

    // Reconfigure over the stored structure, extremes and out-of-range codes.
    write_levels(1, 1, 1, 1, 1);
    random_phase(10);
    write_levels(1, 8, 8, 8, 8);
    random_phase(10);
    write_levels(0, 0, 15, 9, 3);
    random_phase(10);
    write_levels(7, 15, 15, 15, 15);
    random_phase(10);
    write_levels(3, 3, 5, 7, 2);
    random_phase(10);
    write_levels(4, 1, 1, 1, 1);
    random_phase(10);
    write_levels(5, 8, 1, 8, 1);
    random_phase(10);
    write_levels(2, 8, 8, 8, 8);
    random_phase(10);
    for (int p = 0; p < 2; p++) begin
      write_levels(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)));
      random_phase(10);
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
